// ----- rtl/crcfr_pkg.sv -----
// Package for the CRC16 frame receiver: beat payload types, parser phases,
// frame event codes and framing constants. No dependencies.

package crcfr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 16;
   localparam int FEEDBACK_LEN        = 13;
   localparam int STORE_IDX_W         = $clog2(FEEDBACK_LEN);

   localparam logic [7:0]  SOF_A        = 8'hA5;
   localparam logic [7:0]  SOF_B        = 8'h5A;
   localparam logic [7:0]  CMD_FEEDBACK = 8'h90;
   localparam logic [7:0]  CMD_PONG     = 8'h91;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;

   typedef enum logic [2:0] {
      PH_SOF0,
      PH_SOF1,
      PH_SEQ,
      PH_CMD,
      PH_LEN,
      PH_PAY,
      PH_CRCL,
      PH_CRCH
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_FEEDBACK  = 3'd1,
      EV_PONG      = 3'd2,
      EV_OTHER     = 3'd3,
      EV_CRC_ERROR = 3'd4
   } event_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       stale_gap;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         frame_event;
      logic [7:0]         frame_sequence;
      logic               sequence_gap;
      logic signed [31:0] position_a;
      logic signed [31:0] position_b;
      logic signed [15:0] speed_a;
      logic signed [15:0] speed_b;
      logic [7:0]         peer_status;
      logic [31:0]        feedback_total;
      logic [31:0]        crc_fail_total;
      logic [31:0]        gap_total;
      logic [31:0]        pong_total;
   } rsp_payload_type;

endpackage

// ----- rtl/crcfr_if.sv -----
// Valid/ready channel interfaces for the CRC16 frame receiver.
// Depends on crcfr_pkg for the payload types.

interface crcfr_req_if;
   import crcfr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface crcfr_rsp_if;
   import crcfr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/crc16_frame_receiver_unit.sv -----
// Channel   | Dir | Beat contents
// req_bus   | in  | rx_byte, stale_gap
// rsp_bus   | out | frame_event, frame_sequence, sequence_gap, held feedback, counters
//
// One result beat per received byte. A byte can be taken every cycle and its
// result beat is valid in the following cycle: the parser and the byte-wise
// CRC update sit between the state registers and a one-deep result register,
// and req_bus.ready is high whenever that register is empty or being drained
// in the same cycle. Reset is synchronous and clears the parser, held feedback
// values and counters; the payload buffer is not cleared. A stalled result
// holds the input off and keeps all fields.
// Depends on crcfr_pkg and crcfr_if.

module crc16_frame_receiver_unit #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   crcfr_req_if.sink    req_bus,
   crcfr_rsp_if.source  rsp_bus
);
   import crcfr_pkg::*;

   localparam int LW = $clog2(MAX_PAYLOAD + 1);

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   localparam logic [15:0] CRC_AFTER_SOF = crc_step(crc_step(CRC_INIT, SOF_A), SOF_B);

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [7:0]  store_ff [FEEDBACK_LEN];
   logic        store_we;
   logic [STORE_IDX_W-1:0] store_idx;
   logic [7:0]  prev_seq_ff, prev_seq_in;
   logic        seen_ff, seen_in;

   // Held feedback values and counters.
   logic signed [31:0] enc_a_ff, enc_a_in, enc_b_ff, enc_b_in;
   logic signed [15:0] spd_a_ff, spd_a_in, spd_b_ff, spd_b_in;
   logic [7:0]  status_ff, status_in;
   logic [31:0] fb_cnt_ff, fb_cnt_in, crc_cnt_ff, crc_cnt_in;
   logic [31:0] gap_cnt_ff, gap_cnt_in, pong_cnt_ff, pong_cnt_in;

   // Result register.
   logic        rsp_valid_ff;
   event_type   ev_ff, ev_in;
   logic [7:0]  rseq_ff, rseq_in;
   logic        gap_ff, gap_in;

   logic        accept;
   logic [7:0]  b;
   phase_type   cur_phase;
   logic [LW-1:0] cur_pos, cur_len, pos_plus;
   logic [7:0]  cur_cmd;
   logic [15:0] crc_b;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data.rx_byte;
   assign crc_b         = crc_step(crc_ff, b);
   assign pos_plus      = cur_pos + LW'(1);

   always_comb begin
      // A stale gap drops the partial frame before the byte is parsed.
      if (req_bus.data.stale_gap) begin
         cur_phase = PH_SOF0;
         cur_pos   = '0;
         cur_len   = '0;
         cur_cmd   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_len   = len_ff;
         cur_cmd   = cmd_ff;
      end

      phase_in    = cur_phase;
      pos_in      = cur_pos;
      len_in      = cur_len;
      cmd_in      = cur_cmd;
      seq_in      = seq_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      store_we    = 1'b0;
      store_idx   = cur_pos[STORE_IDX_W-1:0];
      prev_seq_in = prev_seq_ff;
      seen_in     = seen_ff;
      enc_a_in    = enc_a_ff;
      enc_b_in    = enc_b_ff;
      spd_a_in    = spd_a_ff;
      spd_b_in    = spd_b_ff;
      status_in   = status_ff;
      fb_cnt_in   = fb_cnt_ff;
      crc_cnt_in  = crc_cnt_ff;
      gap_cnt_in  = gap_cnt_ff;
      pong_cnt_in = pong_cnt_ff;
      ev_in       = EV_NONE;
      rseq_in     = 8'h00;
      gap_in      = 1'b0;

      unique case (cur_phase)
         PH_SOF0: begin
            if (b == SOF_A) phase_in = PH_SOF1;
         end
         PH_SOF1: begin
            if (b == SOF_B) begin
               crc_in   = CRC_AFTER_SOF;
               pos_in   = '0;
               phase_in = PH_SEQ;
            end else if (b != SOF_A) begin
               // The bad byte is not itself taken as a new first start byte.
               phase_in = PH_SOF0;
               pos_in   = '0;
               cmd_in   = '0;
               len_in   = '0;
            end
         end
         PH_SEQ: begin
            seq_in   = b;
            crc_in   = crc_b;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = b;
            crc_in   = crc_b;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            crc_in = crc_b;
            if (int'(b) > MAX_PAYLOAD) begin
               phase_in = PH_SOF0;
               pos_in   = '0;
               cmd_in   = '0;
               len_in   = '0;
            end else begin
               len_in   = LW'(b);
               pos_in   = '0;
               phase_in = (b == 8'h00) ? PH_CRCL : PH_PAY;
            end
         end
         PH_PAY: begin
            crc_in   = crc_b;
            store_we = (cur_pos < LW'(FEEDBACK_LEN));
            pos_in   = pos_plus;
            if (pos_plus >= cur_len) phase_in = PH_CRCL;
         end
         PH_CRCL: begin
            crc_lo_in = b;
            phase_in  = PH_CRCH;
         end
         PH_CRCH: begin
            rseq_in = seq_ff;
            if ({b, crc_lo_ff} == crc_ff) begin
               if (seen_ff && (seq_ff != (prev_seq_ff + 8'd1))) begin
                  gap_in     = 1'b1;
                  gap_cnt_in = gap_cnt_ff + 32'd1;
               end
               seen_in     = 1'b1;
               prev_seq_in = seq_ff;
               ev_in       = EV_OTHER;
               if (cur_cmd == CMD_FEEDBACK && cur_len == LW'(FEEDBACK_LEN)) begin
                  enc_a_in  = {store_ff[0], store_ff[1], store_ff[2], store_ff[3]};
                  enc_b_in  = {store_ff[4], store_ff[5], store_ff[6], store_ff[7]};
                  spd_a_in  = {store_ff[8], store_ff[9]};
                  spd_b_in  = {store_ff[10], store_ff[11]};
                  status_in = store_ff[12];
                  fb_cnt_in = fb_cnt_ff + 32'd1;
                  ev_in     = EV_FEEDBACK;
               end else if (cur_cmd == CMD_PONG && cur_len == '0) begin
                  pong_cnt_in = pong_cnt_ff + 32'd1;
                  ev_in       = EV_PONG;
               end
            end else begin
               crc_cnt_in = crc_cnt_ff + 32'd1;
               ev_in      = EV_CRC_ERROR;
            end
            phase_in = PH_SOF0;
            pos_in   = '0;
            cmd_in   = '0;
            len_in   = '0;
         end
         default: phase_in = PH_SOF0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOF0;
         pos_ff       <= '0;
         len_ff       <= '0;
         cmd_ff       <= '0;
         seq_ff       <= '0;
         crc_ff       <= CRC_INIT;
         crc_lo_ff    <= '0;
         prev_seq_ff  <= '0;
         seen_ff      <= 1'b0;
         enc_a_ff     <= '0;
         enc_b_ff     <= '0;
         spd_a_ff     <= '0;
         spd_b_ff     <= '0;
         status_ff    <= '0;
         fb_cnt_ff    <= '0;
         crc_cnt_ff   <= '0;
         gap_cnt_ff   <= '0;
         pong_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            len_ff       <= len_in;
            cmd_ff       <= cmd_in;
            seq_ff       <= seq_in;
            crc_ff       <= crc_in;
            crc_lo_ff    <= crc_lo_in;
            prev_seq_ff  <= prev_seq_in;
            seen_ff      <= seen_in;
            enc_a_ff     <= enc_a_in;
            enc_b_ff     <= enc_b_in;
            spd_a_ff     <= spd_a_in;
            spd_b_ff     <= spd_b_in;
            status_ff    <= status_in;
            fb_cnt_ff    <= fb_cnt_in;
            crc_cnt_ff   <= crc_cnt_in;
            gap_cnt_ff   <= gap_cnt_in;
            pong_cnt_ff  <= pong_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload bytes and the per-beat result fields need no reset.
   always_ff @(posedge clock) begin
      if (accept && store_we) store_ff[store_idx] <= b;
      if (accept) begin
         ev_ff   <= ev_in;
         rseq_ff <= rseq_in;
         gap_ff  <= gap_in;
      end
   end

   // Held values and counters only change on an accepted beat, which also
   // reloads the result register, so they drive the result directly.
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.data.frame_event    = ev_ff;
   assign rsp_bus.data.frame_sequence = rseq_ff;
   assign rsp_bus.data.sequence_gap   = gap_ff;
   assign rsp_bus.data.position_a     = enc_a_ff;
   assign rsp_bus.data.position_b     = enc_b_ff;
   assign rsp_bus.data.speed_a        = spd_a_ff;
   assign rsp_bus.data.speed_b        = spd_b_ff;
   assign rsp_bus.data.peer_status    = status_ff;
   assign rsp_bus.data.feedback_total = fb_cnt_ff;
   assign rsp_bus.data.crc_fail_total = crc_cnt_ff;
   assign rsp_bus.data.gap_total      = gap_cnt_ff;
   assign rsp_bus.data.pong_total     = pong_cnt_ff;

endmodule

// ----- rtl/crcfr_checker.sv -----
// Port-level checks for crc16_frame_receiver_unit, attached by bind.
// Depends on crcfr_pkg and the channel interfaces of the top level.

module crcfr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input crcfr_pkg::rsp_payload_type rsp_data
);
   import crcfr_pkg::*;

   // A result that is not taken stays and keeps every field.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed or dropped");

   // With the result slot free the block must take a byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off while result slot is empty");

   // Every accepted byte yields a result beat in the next cycle.
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result beat");

   // Beats that close no frame, and CRC failures, never flag a sequence gap.
   a_gap_only_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.frame_event == EV_NONE ||
                    rsp_data.frame_event == EV_CRC_ERROR) |-> !rsp_data.sequence_gap)
      else $error("sequence gap flagged on a beat without a good frame");

endmodule

bind crc16_frame_receiver_unit crcfr_checker u_crcfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);

// ----- verif/tb.sv -----
// Self-checking testbench for crc16_frame_receiver_unit: a queue-fed byte driver, a result
// monitor and an in-bench frame parser predictor that is compared field by field.
// Depends on crcfr_pkg, crcfr_if and the receiver top level.
`timescale 1ns / 1ps

module tb;
   import crcfr_pkg::*;

   localparam int MAX_LEN      = MAX_PAYLOAD_DEFAULT;
   localparam int TOTAL_BYTES  = 1900;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      req_payload_type beat;
      logic            drain_first;
   } queued_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            drv_valid = 1'b0;
   req_payload_type drv_data  = '0;
   logic            drv_ready = 1'b0;

   crcfr_req_if req_bus ();
   crcfr_rsp_if rsp_bus ();

   assign req_bus.valid = drv_valid;
   assign req_bus.data  = drv_data;
   assign rsp_bus.ready = drv_ready;

   crc16_frame_receiver_unit #(.MAX_PAYLOAD(MAX_LEN)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   queued_byte_type rx_byte_queue[$];
   rsp_payload_type expected_results[$];
   logic [7:0]      body_bytes[$];

   int total_items   = 0;
   int sent_count    = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int feedback_seen = 0;
   int pong_seen     = 0;
   int other_seen    = 0;
   int crc_err_seen  = 0;
   int gap_seen      = 0;

   // Predictor state, reset values as the block comes out of reset.
   phase_type   rx_phase       = PH_SOF0;
   logic [4:0]  pay_index      = '0;
   logic [4:0]  pay_length     = '0;
   logic [7:0]  cur_command    = '0;
   logic [7:0]  cur_sequence   = '0;
   logic [15:0] crc_acc        = CRC_INIT;
   logic [7:0]  crc_lo_held    = '0;
   logic [7:0]  payload_bytes[FEEDBACK_LEN];
   logic [7:0]  last_sequence  = '0;
   logic        sequence_valid = 1'b0;
   logic [31:0] held_enc_a     = '0;
   logic [31:0] held_enc_b     = '0;
   logic [15:0] held_spd_a     = '0;
   logic [15:0] held_spd_b     = '0;
   logic [7:0]  held_status    = '0;
   logic [31:0] feedback_count = '0;
   logic [31:0] crc_fail_count = '0;
   logic [31:0] gap_count      = '0;
   logic [31:0] pong_tally     = '0;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++)
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   task automatic restart_hunt();
      rx_phase    = PH_SOF0;
      pay_index   = '0;
      cur_command = '0;
      pay_length  = '0;
   endtask

   task automatic predict_beat(input req_payload_type beat, output rsp_payload_type res);
      logic [7:0]  b;
      logic [15:0] rx_crc;
      logic [7:0]  seq_step;
      event_type   ev;
      logic [7:0]  seq_out;
      logic        gap;
      b       = beat.rx_byte;
      ev      = EV_NONE;
      seq_out = '0;
      gap     = 1'b0;
      if (beat.stale_gap)
         restart_hunt();
      case (rx_phase)
         PH_SOF0: begin
            if (b == SOF_A)
               rx_phase = PH_SOF1;
         end
         PH_SOF1: begin
            if (b == SOF_B) begin
               crc_acc   = crc16_step(crc16_step(CRC_INIT, SOF_A), SOF_B);
               pay_index = '0;
               rx_phase  = PH_SEQ;
            end else if (b != SOF_A) begin
               restart_hunt();
            end
         end
         PH_SEQ: begin
            cur_sequence = b;
            crc_acc      = crc16_step(crc_acc, b);
            rx_phase     = PH_CMD;
         end
         PH_CMD: begin
            cur_command = b;
            crc_acc     = crc16_step(crc_acc, b);
            rx_phase    = PH_LEN;
         end
         PH_LEN: begin
            crc_acc = crc16_step(crc_acc, b);
            if (b > MAX_LEN) begin
               restart_hunt();
            end else begin
               pay_length = b[4:0];
               pay_index  = '0;
               rx_phase   = (b == 8'd0) ? PH_CRCL : PH_PAY;
            end
         end
         PH_PAY: begin
            crc_acc = crc16_step(crc_acc, b);
            if (pay_index < FEEDBACK_LEN)
               payload_bytes[pay_index] = b;
            pay_index = pay_index + 5'd1;
            if (pay_index >= pay_length)
               rx_phase = PH_CRCL;
         end
         PH_CRCL: begin
            crc_lo_held = b;
            rx_phase    = PH_CRCH;
         end
         default: begin
            rx_crc  = {b, crc_lo_held};
            seq_out = cur_sequence;
            if (rx_crc == crc_acc) begin
               // Sequence continuity wraps modulo 256.
               seq_step = cur_sequence - last_sequence;
               if (sequence_valid && seq_step != 8'd1) begin
                  gap       = 1'b1;
                  gap_count = gap_count + 32'd1;
               end
               sequence_valid = 1'b1;
               last_sequence  = cur_sequence;
               ev = EV_OTHER;
               if (cur_command == CMD_FEEDBACK && pay_length == FEEDBACK_LEN) begin
                  held_enc_a = {payload_bytes[0], payload_bytes[1],
                                payload_bytes[2], payload_bytes[3]};
                  held_enc_b = {payload_bytes[4], payload_bytes[5],
                                payload_bytes[6], payload_bytes[7]};
                  held_spd_a  = {payload_bytes[8], payload_bytes[9]};
                  held_spd_b  = {payload_bytes[10], payload_bytes[11]};
                  held_status = payload_bytes[12];
                  feedback_count = feedback_count + 32'd1;
                  ev = EV_FEEDBACK;
               end else if (cur_command == CMD_PONG && pay_length == 5'd0) begin
                  pong_tally = pong_tally + 32'd1;
                  ev = EV_PONG;
               end
            end else begin
               crc_fail_count = crc_fail_count + 32'd1;
               ev = EV_CRC_ERROR;
            end
            restart_hunt();
         end
      endcase
      res.frame_event    = ev;
      res.frame_sequence = seq_out;
      res.sequence_gap   = gap;
      res.position_a     = held_enc_a;
      res.position_b     = held_enc_b;
      res.speed_a        = held_spd_a;
      res.speed_b        = held_spd_b;
      res.peer_status    = held_status;
      res.feedback_total = feedback_count;
      res.crc_fail_total = crc_fail_count;
      res.gap_total      = gap_count;
      res.pong_total     = pong_tally;
   endtask

   // Stimulus builders.
   task automatic push_beat(input logic [7:0] value, input logic stale, input logic drain);
      queued_byte_type item;
      item.beat.rx_byte   = value;
      item.beat.stale_gap = stale;
      item.drain_first    = drain;
      rx_byte_queue.push_back(item);
   endtask

   task automatic make_body(input int len, input int fill);
      body_bytes.delete();
      for (int i = 0; i < len; i++)
         body_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
   endtask

   task automatic send_header(input logic [7:0] seq, input logic [7:0] cmd,
                              input logic [7:0] len, input logic stale, input logic drain);
      push_beat(SOF_A, stale, drain);
      push_beat(SOF_B, 1'b0, 1'b0);
      push_beat(seq, 1'b0, 1'b0);
      push_beat(cmd, 1'b0, 1'b0);
      push_beat(len, 1'b0, 1'b0);
   endtask

   // Whole frame around body_bytes; a corrupted frame has one CRC bit flipped.
   task automatic queue_frame(input logic [7:0] seq, input logic [7:0] cmd, input bit corrupt,
                              input logic stale, input logic drain);
      logic [15:0] crc;
      logic [7:0]  len;
      len = 8'(body_bytes.size());
      crc = crc16_step(crc16_step(crc16_step(crc16_step(crc16_step(CRC_INIT, SOF_A),
            SOF_B), seq), cmd), len);
      foreach (body_bytes[i])
         crc = crc16_step(crc, body_bytes[i]);
      if (corrupt)
         crc = crc ^ (16'd1 << $urandom_range(15));
      send_header(seq, cmd, len, stale, drain);
      foreach (body_bytes[i])
         push_beat(body_bytes[i], 1'b0, 1'b0);
      push_beat(crc[7:0], 1'b0, 1'b0);
      push_beat(crc[15:8], 1'b0, 1'b0);
   endtask

   // Three idling regimes by progress: receiver-heavy stalls, sender-heavy, then none.
   function automatic int idle_pct(input bit sender_side);
      if (sent_count < total_items / 3)
         return sender_side ? 14 : 88;
      else if (sent_count < (2 * total_items) / 3)
         return sender_side ? 88 : 14;
      return 0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endtask

   queued_byte_type next_item;
   rsp_payload_type predicted;
   rsp_payload_type want;

   // Driver: predicts each accepted beat, then offers the next queued byte.
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_beat(req_bus.data, predicted);
            expected_results.push_back(predicted);
            sent_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (rx_byte_queue.size() != 0 &&
                !(rx_byte_queue[0].drain_first && expected_results.size() != 0) &&
                $urandom_range(99) >= idle_pct(1'b1)) begin
               next_item = rx_byte_queue.pop_front();
               drv_data  <= next_item.beat;
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         drv_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $error("result beat arrived with no prediction waiting");
            end else begin
               want = expected_results.pop_front();
               check_field("frame_event", 32'(want.frame_event), 32'(rsp_bus.data.frame_event));
               check_field("frame_sequence", 32'(want.frame_sequence),
                           32'(rsp_bus.data.frame_sequence));
               check_field("sequence_gap", 32'(want.sequence_gap),
                           32'(rsp_bus.data.sequence_gap));
               check_field("position_a", want.position_a, rsp_bus.data.position_a);
               check_field("position_b", want.position_b, rsp_bus.data.position_b);
               check_field("speed_a", 32'(unsigned'(want.speed_a)),
                           32'(unsigned'(rsp_bus.data.speed_a)));
               check_field("speed_b", 32'(unsigned'(want.speed_b)),
                           32'(unsigned'(rsp_bus.data.speed_b)));
               check_field("peer_status", 32'(want.peer_status),
                           32'(rsp_bus.data.peer_status));
               check_field("feedback_total", want.feedback_total, rsp_bus.data.feedback_total);
               check_field("crc_fail_total", want.crc_fail_total, rsp_bus.data.crc_fail_total);
               check_field("gap_total", want.gap_total, rsp_bus.data.gap_total);
               check_field("pong_total", want.pong_total, rsp_bus.data.pong_total);
               case (event_type'(want.frame_event))
                  EV_FEEDBACK:  feedback_seen++;
                  EV_PONG:      pong_seen++;
                  EV_OTHER:     other_seen++;
                  EV_CRC_ERROR: crc_err_seen++;
                  default:      ;
               endcase
               if (want.sequence_gap)
                  gap_seen++;
            end
         end
         drv_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int         pick;
      int         len;
      int         cut;
      logic [7:0] seq;
      logic [7:0] seq_next;
      logic [7:0] junk;
      bit         force_stale;
      bit         stale;
      bit         drain;
      bit         corrupt;

      // Directed frames: hunt extremes, repeated start, first good frame as an empty pong.
      push_beat(8'h00, 1'b1, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0);
      push_beat(SOF_A, 1'b0, 1'b0);
      make_body(0, 0);
      queue_frame(8'hFF, CMD_PONG, 1'b0, 1'b0, 1'b0);
      // Feedback with extreme signed values; sequence wraps from FF to 00.
      body_bytes = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
                     8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF};
      queue_frame(8'h00, CMD_FEEDBACK, 1'b0, 1'b0, 1'b0);
      body_bytes = '{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
                     8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00};
      queue_frame(8'h01, CMD_FEEDBACK, 1'b0, 1'b0, 1'b0);
      // Bad second start byte, then oversized lengths at both ends.
      push_beat(SOF_A, 1'b0, 1'b0);
      push_beat(8'h12, 1'b0, 1'b0);
      send_header(8'h02, 8'h33, 8'(MAX_LEN + 1), 1'b0, 1'b0);
      send_header(8'h02, 8'h33, 8'hFF, 1'b0, 1'b0);
      // Longest payload on an unknown command.
      make_body(MAX_LEN, -1);
      queue_frame(8'h02, 8'h00, 1'b0, 1'b0, 1'b0);
      // Feedback of the wrong length and pong with a payload are plain good frames.
      make_body(FEEDBACK_LEN - 1, 8'h5C);
      queue_frame(8'h03, CMD_FEEDBACK, 1'b0, 1'b0, 1'b0);
      make_body(1, 8'h00);
      queue_frame(8'h04, CMD_PONG, 1'b0, 1'b0, 1'b0);
      make_body(FEEDBACK_LEN, 8'hFF);
      queue_frame(8'h05, CMD_FEEDBACK, 1'b1, 1'b0, 1'b0);
      make_body(0, 0);
      queue_frame(8'h40, CMD_PONG, 1'b0, 1'b0, 1'b0);
      // Partial frame abandoned by a stale gap on the next start byte.
      send_header(8'h41, CMD_FEEDBACK, 8'(FEEDBACK_LEN), 1'b0, 1'b0);
      push_beat(8'h11, 1'b0, 1'b0);
      make_body(FEEDBACK_LEN, 8'h00);
      queue_frame(8'h41, CMD_FEEDBACK, 1'b0, 1'b1, 1'b0);

      // Random part: mostly well-formed frames, the rest noise and broken frames.
      seq_next    = 8'h42;
      force_stale = 1'b0;
      drain       = 1'b1;
      while (rx_byte_queue.size() < TOTAL_BYTES) begin
         pick    = $urandom_range(99);
         stale   = force_stale || ($urandom_range(15) == 0);
         corrupt = ($urandom_range(9) == 0);
         seq     = ($urandom_range(11) == 0) ? 8'($urandom) : seq_next;
         force_stale = 1'b0;
         if (pick < 30) begin
            len = ($urandom_range(6) == 0) ? $urandom_range(MAX_LEN) : FEEDBACK_LEN;
            make_body(len, -1);
            queue_frame(seq, CMD_FEEDBACK, corrupt, stale, drain);
            seq_next = seq + 8'd1;
         end else if (pick < 50) begin
            len = ($urandom_range(4) == 0) ? $urandom_range(1, MAX_LEN) : 0;
            make_body(len, -1);
            queue_frame(seq, CMD_PONG, corrupt, stale, drain);
            seq_next = seq + 8'd1;
         end else if (pick < 75) begin
            make_body($urandom_range(MAX_LEN), -1);
            queue_frame(seq, 8'($urandom), corrupt, stale, drain);
            seq_next = seq + 8'd1;
         end else if (pick < 82) begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
               push_beat(8'($urandom), 1'($urandom), drain && (i == 1));
         end else if (pick < 88) begin
            // Truncated frame; the next item carries a stale gap unless it is noise or a repeated start.
            cut = $urandom_range(3);
            if (cut == 0) begin
               push_beat(SOF_A, stale, drain);
               push_beat(SOF_B, 1'b0, 1'b0);
               for (int i = $urandom_range(2); i > 0; i--)
                  push_beat(8'($urandom), 1'b0, 1'b0);
            end else begin
               len = $urandom_range(1, MAX_LEN);
               send_header(seq, 8'($urandom), 8'(len), stale, drain);
               for (int i = $urandom_range(len + 1); i > 0; i--)
                  push_beat(8'($urandom), 1'b0, 1'b0);
            end
            force_stale = 1'b1;
         end else if (pick < 93) begin
            send_header(seq, 8'($urandom), 8'($urandom_range(MAX_LEN + 1, 255)), stale, drain);
         end else if (pick < 97) begin
            push_beat(SOF_A, stale, drain);
            if ($urandom_range(1) == 0) begin
               force_stale = 1'b1;
            end else begin
               junk = 8'($urandom);
               if (junk == SOF_A || junk == SOF_B)
                  junk = 8'h00;
               push_beat(junk, 1'b0, 1'b0);
            end
         end else begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
               push_beat(SOF_A, 1'b0, drain && (i == 1));
            make_body($urandom_range(MAX_LEN), -1);
            queue_frame(seq, 8'($urandom), corrupt, 1'b0, 1'b0);
            seq_next = seq + 8'd1;
         end
         drain = ($urandom_range(59) == 0);
      end
      total_items = rx_byte_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_items || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Drove %0d bytes through hunt, header, payload, CRC and stale-gap paths.",
               sent_count);
      $display("Frames seen: %0d feedback, %0d pong, %0d other good, %0d CRC errors, %0d gaps.",
               feedback_seen, pong_seen, other_seen, crc_err_seen, gap_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
